// ===== rtl/rpc_frame_deframer_core_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef RPC_FRAME_DEFRAMER_CORE_MACROS_SVH
`define RPC_FRAME_DEFRAMER_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rfd assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define RFD_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rfd forbidden condition seen");

`endif

// ===== rtl/rfd_pkg.sv =====
package rfd_pkg;

   // parser phases
   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_LEN     = 4'd1,
      PH_IDLEN   = 4'd2,
      PH_ID      = 4'd3,
      PH_MLEN    = 4'd4,
      PH_MNAME   = 4'd5,
      PH_ECODE   = 4'd6,
      PH_ILEN    = 4'd7,
      PH_INFO    = 4'd8,
      PH_PAYLOAD = 4'd9,
      PH_CSUM    = 4'd10,
      PH_END     = 4'd11
   } rfd_phase_type;

   // field kinds
   localparam logic [2:0] KIND_REQ_ID  = 3'd0;
   localparam logic [2:0] KIND_METHOD  = 3'd1;
   localparam logic [2:0] KIND_INFO    = 3'd2;
   localparam logic [2:0] KIND_PAYLOAD = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;

   // frame status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NO_END    = 2'd1;
   localparam logic [1:0] STAT_MALFORMED = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_START_BYTE   = 2'd0;
   localparam logic [1:0] CSR_END_BYTE     = 2'd1;
   localparam logic [1:0] CSR_MAX_ID_LEN   = 2'd2;
   localparam logic [1:0] CSR_MAX_INFO_LEN = 2'd3;

   // register reset values
   localparam logic [7:0]  START_BYTE_RST   = 8'd2;
   localparam logic [7:0]  END_BYTE_RST     = 8'd3;
   localparam logic [15:0] MAX_ID_LEN_RST   = 16'd99;
   localparam logic [15:0] MAX_INFO_LEN_RST = 16'd511;

   // bytes of a frame outside the three strings and the payload
   localparam logic [30:0] FIXED_BYTES = 31'd26;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [15:0] max_id_len;
      logic [15:0] max_info_len;
   } rfd_cfg_type;

   typedef struct packed {
      logic [7:0]         data_byte;
      logic [2:0]         field_kind;
      logic signed [31:0] error_code;
      logic [30:0]        frame_length;
      logic [1:0]         frame_status;
      logic               frame_last;
   } rfd_result_type;

endpackage

// ===== rtl/rpc_frame_deframer_core.sv =====
// Byte-serial deframer for length-prefixed RPC frames.
// Input channel req_*: one raw stream byte per item (req_in_byte).
// Result channel rsp_*: content bytes of the request id, method name,
// error info and payload fields, tagged by rsp_field_kind, and one closing
// item per frame (rsp_frame_last high) with error code, frame length and
// status (ok, end marker missing, malformed lengths).
// CSR port csr_*: start byte, end byte and string length limits; write
// only while the block is idle.
// A result is registered in the two-entry output buffer before it appears
// on rsp_*. One byte per cycle is accepted while the buffer has room; the
// parse step between parser state and output buffer is combinational.
// When the receiver stalls, the buffer absorbs one extra result and then
// drops req_ready; bytes that cause no result are still taken while the
// buffer has room. Reset clears the parser to hunting for the start byte,
// empties the buffer and restores register defaults; no clearing pass.
module rpc_frame_deframer_core import rfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_data_byte,
   output logic [2:0]         rsp_field_kind,
   output logic signed [31:0] rsp_error_code,
   output logic [30:0]        rsp_frame_length,
   output logic [1:0]         rsp_frame_status,
   output logic               rsp_frame_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_addr,
   input  logic [15:0]        csr_wdata
);

   rfd_cfg_type    cfg_ff;
   rfd_result_type res;
   rfd_result_type rsp_data;
   logic           res_valid;
   logic           step;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte   <= START_BYTE_RST;
         cfg_ff.end_byte     <= END_BYTE_RST;
         cfg_ff.max_id_len   <= MAX_ID_LEN_RST;
         cfg_ff.max_info_len <= MAX_INFO_LEN_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_START_BYTE:   cfg_ff.start_byte   <= csr_wdata[7:0];
            CSR_END_BYTE:     cfg_ff.end_byte     <= csr_wdata[7:0];
            CSR_MAX_ID_LEN:   cfg_ff.max_id_len   <= csr_wdata;
            CSR_MAX_INFO_LEN: cfg_ff.max_info_len <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign step = req_valid && req_ready;

   rfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (req_in_byte),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   rfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_data_byte    = rsp_data.data_byte;
   assign rsp_field_kind   = rsp_data.field_kind;
   assign rsp_error_code   = rsp_data.error_code;
   assign rsp_frame_length = rsp_data.frame_length;
   assign rsp_frame_status = rsp_data.frame_status;
   assign rsp_frame_last   = rsp_data.frame_last;

endmodule

// ===== rtl/rfd_parser.sv =====
`include "rpc_frame_deframer_core_macros.svh"

module rfd_parser import rfd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     in_byte,
   input  rfd_cfg_type    cfg,
   output logic           res_valid,
   output rfd_result_type res
);

   rfd_phase_type phase_ff, phase_in;
   logic [23:0]   word_ff, word_in;
   logic [1:0]    byte_idx_ff, byte_idx_in;
   logic [30:0]   declared_ff, declared_in;
   logic [30:0]   room_ff, room_in;     // declared - 26 - strings so far
   logic [30:0]   remain_ff, remain_in; // bytes left in current content field
   logic [31:0]   err_ff, err_in;

   logic [31:0] word_w;
   logic        word_done;
   logic [15:0] len_max;
   logic [15:0] len16;
   logic        len_bad;
   logic        frame_bad_len;
   logic [30:0] room_after;
   logic [30:0] remain_dec;
   logic        remain_zero;
   logic        close_event;
   logic [1:0]  close_status;
   logic        data_phase;
   logic        len_phase;

   // shared decode
   assign word_w        = {word_ff, in_byte};
   assign word_done     = (byte_idx_ff == 2'd3);
   assign len16         = word_w[15:0];
   assign len_max       = (phase_ff == PH_ILEN) ? cfg.max_info_len : cfg.max_id_len;
   assign len_bad       = (word_w[31:16] != 16'd0) || (len16 > len_max) ||
                          ({15'd0, len16} > room_ff);
   assign room_after    = room_ff - {15'd0, len16};
   assign frame_bad_len = word_w[31] || (word_w[30:0] < FIXED_BYTES);
   assign remain_dec    = (remain_ff == 31'd0) ? 31'd0 : remain_ff - 31'd1;
   assign remain_zero   = (remain_dec == 31'd0);
   assign len_phase     = (phase_ff == PH_IDLEN) || (phase_ff == PH_MLEN) ||
                          (phase_ff == PH_ILEN);
   assign data_phase    = (phase_ff == PH_ID) || (phase_ff == PH_MNAME) ||
                          (phase_ff == PH_INFO) || (phase_ff == PH_PAYLOAD);

   // closing conditions
   always_comb begin
      close_event  = 1'b0;
      close_status = STAT_MALFORMED;
      if (phase_ff == PH_END) begin
         close_event  = 1'b1;
         close_status = (in_byte == cfg.end_byte) ? STAT_OK : STAT_NO_END;
      end else if (word_done && (phase_ff == PH_LEN) && frame_bad_len) begin
         close_event = 1'b1;
      end else if (word_done && len_phase && len_bad) begin
         close_event = 1'b1;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (in_byte == cfg.start_byte) phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (word_done) phase_in = frame_bad_len ? PH_HUNT : PH_IDLEN;
            end
            PH_IDLEN: begin
               if (word_done) begin
                  if (len_bad)              phase_in = PH_HUNT;
                  else if (len16 != 16'd0)  phase_in = PH_ID;
                  else                      phase_in = PH_MLEN;
               end
            end
            PH_ID: begin
               if (remain_zero) phase_in = PH_MLEN;
            end
            PH_MLEN: begin
               if (word_done) begin
                  if (len_bad)              phase_in = PH_HUNT;
                  else if (len16 != 16'd0)  phase_in = PH_MNAME;
                  else                      phase_in = PH_ECODE;
               end
            end
            PH_MNAME: begin
               if (remain_zero) phase_in = PH_ECODE;
            end
            PH_ECODE: begin
               if (word_done) phase_in = PH_ILEN;
            end
            PH_ILEN: begin
               if (word_done) begin
                  if (len_bad)                   phase_in = PH_HUNT;
                  else if (len16 != 16'd0)       phase_in = PH_INFO;
                  else if (room_after != 31'd0)  phase_in = PH_PAYLOAD;
                  else                           phase_in = PH_CSUM;
               end
            end
            PH_INFO: begin
               if (remain_zero) phase_in = (room_ff != 31'd0) ? PH_PAYLOAD : PH_CSUM;
            end
            PH_PAYLOAD: begin
               if (remain_zero) phase_in = PH_CSUM;
            end
            PH_CSUM: begin
               if (word_done) phase_in = PH_END;
            end
            PH_END: begin
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      word_in     = word_ff;
      byte_idx_in = byte_idx_ff;
      declared_in = declared_ff;
      room_in     = room_ff;
      remain_in   = remain_ff;
      err_in      = err_ff;

      res_valid        = 1'b0;
      res.data_byte    = 8'd0;
      res.field_kind   = KIND_END;
      res.error_code   = 32'sd0;
      res.frame_length = 31'd0;
      res.frame_status = STAT_OK;
      res.frame_last   = 1'b0;

      if (step) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (in_byte == cfg.start_byte) begin
                  word_in     = 24'd0;
                  byte_idx_in = 2'd0;
                  declared_in = 31'd0;
                  room_in     = 31'd0;
                  remain_in   = 31'd0;
                  err_in      = 32'd0;
               end
            end
            PH_LEN, PH_IDLEN, PH_MLEN, PH_ECODE, PH_ILEN, PH_CSUM: begin
               word_in     = word_w[23:0];
               byte_idx_in = byte_idx_ff + 2'd1;
               if (word_done) begin
                  if (phase_ff == PH_LEN) begin
                     declared_in = word_w[30:0];
                     room_in     = word_w[30:0] - FIXED_BYTES;
                  end else if (phase_ff == PH_ECODE) begin
                     err_in = word_w;
                  end else if (len_phase && !len_bad) begin
                     room_in   = room_after;
                     remain_in = {15'd0, len16};
                     // empty info string goes straight to the payload
                     if ((phase_ff == PH_ILEN) && (len16 == 16'd0)) remain_in = room_after;
                  end
               end
            end
            PH_ID, PH_MNAME, PH_INFO, PH_PAYLOAD: begin
               remain_in = remain_dec;
               if ((phase_ff == PH_INFO) && remain_zero) remain_in = room_ff;
            end
            default: begin
            end
         endcase

         // content byte
         if (data_phase) begin
            res_valid     = 1'b1;
            res.data_byte = in_byte;
            unique case (phase_ff)
               PH_ID:    res.field_kind = KIND_REQ_ID;
               PH_MNAME: res.field_kind = KIND_METHOD;
               PH_INFO:  res.field_kind = KIND_INFO;
               default:  res.field_kind = KIND_PAYLOAD;
            endcase
         end else if (close_event) begin
            res_valid        = 1'b1;
            res.field_kind   = KIND_END;
            res.error_code   = err_ff;
            res.frame_length = (phase_ff == PH_LEN) ? word_w[30:0] : declared_ff;
            res.frame_status = close_status;
            res.frame_last   = 1'b1;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         word_ff     <= 24'd0;
         byte_idx_ff <= 2'd0;
         declared_ff <= 31'd0;
         room_ff     <= 31'd0;
         remain_ff   <= 31'd0;
         err_ff      <= 32'd0;
      end else begin
         phase_ff    <= phase_in;
         word_ff     <= word_in;
         byte_idx_ff <= byte_idx_in;
         declared_ff <= declared_in;
         room_ff     <= room_in;
         remain_ff   <= remain_in;
         err_ff      <= err_in;
      end
   end

   // a closing item always sends the parser back to hunting
   `RFD_ASSERT(a_close_hunts, clock, reset, (res_valid && res.frame_last) |=> (phase_ff == PH_HUNT))
   // content phases are only ever entered with bytes still to come
   `RFD_ASSERT_NEVER(a_data_nonempty, clock, reset, data_phase && (remain_ff == 31'd0))
   // the closing item is always tagged as frame end
   `RFD_ASSERT(a_close_kind, clock, reset, (res_valid && res.frame_last) |-> (res.field_kind == KIND_END))
   // results only come from an accepted byte
   `RFD_ASSERT_NEVER(a_res_needs_step, clock, reset, res_valid && !step)

endmodule

// ===== rtl/rfd_out_buf.sv =====
`include "rpc_frame_deframer_core_macros.svh"

module rfd_out_buf import rfd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rfd_result_type push_data,
   output logic           in_ready,
   output logic           out_valid,
   input  logic           out_ready,
   output rfd_result_type out_data
);

   logic           main_valid_ff, main_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   rfd_result_type main_ff, main_in;
   rfd_result_type skid_ff, skid_in;
   logic           pop;

   assign pop       = main_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // two-entry buffer: output register plus skid register
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // skid only fills behind a full output register
   `RFD_ASSERT_NEVER(a_skid_behind_main, clock, reset, skid_valid_ff && !main_valid_ff)
   // nothing is pushed while the skid register is occupied
   `RFD_ASSERT_NEVER(a_no_push_full, clock, reset, push && skid_valid_ff)
   // a waiting skid item moves up when the output item is taken
   `RFD_ASSERT(a_skid_drains, clock, reset, (pop && skid_valid_ff) |=> main_valid_ff)

endmodule
